@@ rtl/circle_box_collide_push_out_assert.svh @@
// Assertion macros for the circle/box collision block.
// Used by the top level; depends on clk and arst_n in the including scope.
`ifndef CIRCLE_BOX_COLLIDE_PUSH_OUT_ASSERT_SVH
`define CIRCLE_BOX_COLLIDE_PUSH_OUT_ASSERT_SVH

// Condition a implies condition c in the same cycle.
`define CBC_ASSERT_SAME(label, a, c, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (a) |-> (c)) \
		else $error(msg);

// Condition a implies condition c in the next cycle.
`define CBC_ASSERT_NEXT(label, a, c, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (a) |=> (c)) \
		else $error(msg);

`endif

@@ rtl/cbc_pkg.sv @@
// Shared widths, stage counts and register indexes for the circle/box collision block.
// No dependencies.
package cbc_pkg;
	localparam int COORD_W    = 16;
	localparam int RAD_W      = 14;
	localparam int SQ_W       = 2 * RAD_W;
	localparam int SQ_STAGES  = RAD_W;
	localparam int SQ_REM_W   = RAD_W + 3;
	localparam int DIV_STAGES = RAD_W + 1;
	localparam int DIV_N_W    = SQ_W + 1;
	localparam int DIV_D_W    = RAD_W + 1;
	localparam int CFG_IDX_W  = 3;
	localparam int OUT_W      = 72;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_LEFT   = 3'd0,
		CFG_TOP    = 3'd1,
		CFG_WIDTH  = 3'd2,
		CFG_HEIGHT = 3'd3,
		CFG_RADIUS = 3'd4
	} cfg_idx_t;

	typedef struct packed {
		logic signed [COORD_W-1:0] cx;
		logic signed [COORD_W-1:0] cy;
		logic signed [COORD_W-1:0] nx;
		logic signed [COORD_W-1:0] ny;
		logic                      sx;
		logic                      sy;
		logic [RAD_W-1:0]          adx;
		logic [RAD_W-1:0]          ady;
		logic                      hit;
		logic                      push;
	} side_t;
endpackage

@@ rtl/circle_box_collide_push_out.sv @@
// Circle against axis-aligned box collision test with push-out.
// Top level; depends on cbc_pkg, cbc_sqrt, cbc_div and the assertion macro header.
//
// Usage: write the box and radius through cfg_we/cfg_index/cfg_data while the
// block is idle. Each word on the s_axis channel carries one circle centre
// and gives exactly one result word on the m_axis channel, in order.
// Each accepted word passes through the clamp, square, sum, 14 square-root
// stages, one multiply stage, 15 divider stages and the output register before
// its result shows on m_axis_tvalid. One word is taken every cycle unless the
// receiver stalls the pipeline; the depth of the square root and divider sets the latency.
// Reset clears all valid bits and loads the default box and radius.
// When the receiver holds m_axis_tready low with a result waiting, the whole
// pipeline freezes and s_axis_tready drops; nothing is lost or repeated.
module circle_box_collide_push_out
	import cbc_pkg::*;
(
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 s_axis_tvalid,
	output logic                 s_axis_tready,
	// center_x [15:0], center_y [31:16]
	input  logic [31:0]          s_axis_tdata,
	output logic                 m_axis_tvalid,
	input  logic                 m_axis_tready,
	// collided [0], nearest_x [16:1], nearest_y [32:17],
	// resolved_x [48:33], resolved_y [64:49], zero fill [71:65]
	output logic [OUT_W-1:0]     m_axis_tdata,
	input  logic                 cfg_we,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [COORD_W-1:0]   cfg_data
);
	`include "circle_box_collide_push_out_assert.svh"

	localparam int NSTG = 3 + SQ_STAGES + 1 + DIV_STAGES + 1;

	logic signed [COORD_W-1:0] left_q, top_q;
	logic [COORD_W-2:0]        width_q, height_q;
	logic [RAD_W-1:0]          radius_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			left_q   <= '0;
			top_q    <= '0;
			width_q  <= 15'd1600;
			height_q <= 15'd1600;
			radius_q <= 14'd800;
		end else if (cfg_we) begin
			case (cfg_idx_t'(cfg_index))
				CFG_LEFT:   left_q   <= cfg_data;
				CFG_TOP:    top_q    <= cfg_data;
				CFG_WIDTH:  width_q  <= cfg_data[COORD_W-2:0];
				CFG_HEIGHT: height_q <= cfg_data[COORD_W-2:0];
				CFG_RADIUS: radius_q <= cfg_data[RAD_W-1:0];
				default: ;
			endcase
		end
	end

	logic            ce;
	logic [NSTG-1:0] vld_q;

	assign ce            = !vld_q[NSTG-1] || m_axis_tready;
	assign s_axis_tready = ce;
	assign m_axis_tvalid = vld_q[NSTG-1];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else if (ce) begin
			vld_q <= {vld_q[NSTG-2:0], s_axis_tvalid};
		end
	end

	// Stage 1: clamp into the box.
	logic signed [COORD_W-1:0] in_cx, in_cy, nx_c, ny_c;
	logic signed [COORD_W:0]   right_c, bottom_c, cx_e, cy_e;
	logic signed [COORD_W-1:0] cx_s1, cy_s1, nx_s1, ny_s1;
	logic signed [COORD_W:0]   dx_s1, dy_s1;

	assign in_cx    = s_axis_tdata[COORD_W-1:0];
	assign in_cy    = s_axis_tdata[2*COORD_W-1:COORD_W];
	assign cx_e     = {in_cx[COORD_W-1], in_cx};
	assign cy_e     = {in_cy[COORD_W-1], in_cy};
	assign right_c  = {left_q[COORD_W-1], left_q} + $signed({2'b00, width_q});
	assign bottom_c = {top_q[COORD_W-1], top_q} + $signed({2'b00, height_q});

	always_comb begin
		if (in_cx < left_q) begin
			nx_c = left_q;
		end else if (cx_e > right_c) begin
			nx_c = right_c[COORD_W-1:0];
		end else begin
			nx_c = in_cx;
		end
		if (in_cy < top_q) begin
			ny_c = top_q;
		end else if (cy_e > bottom_c) begin
			ny_c = bottom_c[COORD_W-1:0];
		end else begin
			ny_c = in_cy;
		end
	end

	always_ff @(posedge clk) begin
		if (ce) begin
			cx_s1 <= in_cx;
			cy_s1 <= in_cy;
			nx_s1 <= nx_c;
			ny_s1 <= ny_c;
			dx_s1 <= cx_e - {nx_c[COORD_W-1], nx_c};
			dy_s1 <= cy_e - {ny_c[COORD_W-1], ny_c};
		end
	end

	// Stage 2: magnitudes and squares.
	logic [COORD_W:0] adx_c, ady_c;
	logic             inr_c;
	logic [SQ_W-1:0]  sqx_s2, sqy_s2, r2_s2;
	side_t            side_s2, side_c3, side_s3;

	assign adx_c = dx_s1[COORD_W] ? (COORD_W+1)'(-dx_s1) : dx_s1;
	assign ady_c = dy_s1[COORD_W] ? (COORD_W+1)'(-dy_s1) : dy_s1;
	assign inr_c = (adx_c <= {3'b000, radius_q}) && (ady_c <= {3'b000, radius_q});

	always_ff @(posedge clk) begin
		if (ce) begin
			sqx_s2       <= {{RAD_W{1'b0}}, adx_c[RAD_W-1:0]}
				* {{RAD_W{1'b0}}, adx_c[RAD_W-1:0]};
			sqy_s2       <= {{RAD_W{1'b0}}, ady_c[RAD_W-1:0]}
				* {{RAD_W{1'b0}}, ady_c[RAD_W-1:0]};
			r2_s2        <= {{RAD_W{1'b0}}, radius_q} * {{RAD_W{1'b0}}, radius_q};
			side_s2.cx   <= cx_s1;
			side_s2.cy   <= cy_s1;
			side_s2.nx   <= nx_s1;
			side_s2.ny   <= ny_s1;
			side_s2.sx   <= dx_s1[COORD_W];
			side_s2.sy   <= dy_s1[COORD_W];
			side_s2.adx  <= adx_c[RAD_W-1:0];
			side_s2.ady  <= ady_c[RAD_W-1:0];
			side_s2.hit  <= inr_c;
			side_s2.push <= inr_c;
		end
	end

	// Stage 3: distance squared against radius squared.
	logic [SQ_W:0]   d2_c;
	logic [SQ_W-1:0] d2_s3;

	assign d2_c = {1'b0, sqx_s2} + {1'b0, sqy_s2};

	always_comb begin
		side_c3      = side_s2;
		side_c3.hit  = side_s2.hit && (d2_c <= {1'b0, r2_s2});
		side_c3.push = side_s2.push && (d2_c != '0) && (d2_c < {1'b0, r2_s2});
	end

	always_ff @(posedge clk) begin
		if (ce) begin
			d2_s3   <= d2_c[SQ_W-1:0];
			side_s3 <= side_c3;
		end
	end

	// Square root, with side data delayed alongside.
	logic [RAD_W-1:0] root;
	side_t            side_sq_s4 [0:SQ_STAGES-1];

	cbc_sqrt u_sqrt (
		.clk   (clk),
		.ce    (ce),
		.value (d2_s3),
		.root  (root)
	);

	always_ff @(posedge clk) begin
		if (ce) begin
			side_sq_s4[0] <= side_s3;
			for (int k = 1; k < SQ_STAGES; k++) begin
				side_sq_s4[k] <= side_sq_s4[k-1];
			end
		end
	end

	// Multiply stage: offset times remaining gap.
	logic [RAD_W-1:0] gap_c, d_s18;
	logic [SQ_W-1:0]  numx_s18, numy_s18;
	side_t            side_s18;

	assign gap_c = radius_q - root;

	always_ff @(posedge clk) begin
		if (ce) begin
			numx_s18 <= {{RAD_W{1'b0}}, side_sq_s4[SQ_STAGES-1].adx}
				* {{RAD_W{1'b0}}, gap_c};
			numy_s18 <= {{RAD_W{1'b0}}, side_sq_s4[SQ_STAGES-1].ady}
				* {{RAD_W{1'b0}}, gap_c};
			d_s18    <= root;
			side_s18 <= side_sq_s4[SQ_STAGES-1];
		end
	end

	// Dividers, with side data delayed alongside.
	logic [DIV_D_W-1:0] qx, qy;
	side_t              side_dv_s19 [0:DIV_STAGES-1];

	cbc_div u_div_x (
		.clk  (clk),
		.ce   (ce),
		.num  (numx_s18),
		.d    (d_s18),
		.quot (qx)
	);

	cbc_div u_div_y (
		.clk  (clk),
		.ce   (ce),
		.num  (numy_s18),
		.d    (d_s18),
		.quot (qy)
	);

	always_ff @(posedge clk) begin
		if (ce) begin
			side_dv_s19[0] <= side_s18;
			for (int k = 1; k < DIV_STAGES; k++) begin
				side_dv_s19[k] <= side_dv_s19[k-1];
			end
		end
	end

	// Output stage: apply the push and saturate.
	localparam logic signed [COORD_W+1:0] SAT_HI = (COORD_W+2)'(2**(COORD_W-1) - 1);
	localparam logic signed [COORD_W+1:0] SAT_LO = -SAT_HI - 18'sd1;

	side_t                     sd;
	logic signed [COORD_W+1:0] px_c, py_c, sumx_c, sumy_c;
	logic signed [COORD_W-1:0] rx_c, ry_c;
	logic [OUT_W-1:0]          out_s34;

	assign sd     = side_dv_s19[DIV_STAGES-1];
	assign px_c   = sd.sx ? -$signed({3'b000, qx}) : $signed({3'b000, qx});
	assign py_c   = sd.sy ? -$signed({3'b000, qy}) : $signed({3'b000, qy});
	assign sumx_c = {{2{sd.cx[COORD_W-1]}}, sd.cx} + px_c;
	assign sumy_c = {{2{sd.cy[COORD_W-1]}}, sd.cy} + py_c;

	always_comb begin
		if (!sd.push) begin
			rx_c = sd.cx;
		end else if (sumx_c > SAT_HI) begin
			rx_c = SAT_HI[COORD_W-1:0];
		end else if (sumx_c < SAT_LO) begin
			rx_c = SAT_LO[COORD_W-1:0];
		end else begin
			rx_c = sumx_c[COORD_W-1:0];
		end
		if (!sd.push) begin
			ry_c = sd.cy;
		end else if (sumy_c > SAT_HI) begin
			ry_c = SAT_HI[COORD_W-1:0];
		end else if (sumy_c < SAT_LO) begin
			ry_c = SAT_LO[COORD_W-1:0];
		end else begin
			ry_c = sumy_c[COORD_W-1:0];
		end
	end

	always_ff @(posedge clk) begin
		if (ce) begin
			out_s34 <= {7'b0, ry_c, rx_c, sd.ny, sd.nx, sd.hit};
		end
	end

	assign m_axis_tdata = out_s34;

	`CBC_ASSERT_SAME(a_push_hits, vld_q[2] && side_s3.push, side_s3.hit,
		"push without collision")
	`CBC_ASSERT_SAME(a_root_range, vld_q[NSTG-17] && side_s18.push,
		(d_s18 != '0) && (d_s18 < radius_q), "root out of range on push")
	`CBC_ASSERT_NEXT(a_stall_hold, !ce, $stable(vld_q), "pipeline moved while stalled")
endmodule

@@ rtl/cbc_sqrt.sv @@
// Pipelined integer square root, one root bit per stage.
// Depends on cbc_pkg.
module cbc_sqrt
	import cbc_pkg::*;
(
	input  logic             clk,
	input  logic             ce,
	input  logic [SQ_W-1:0]  value,
	output logic [RAD_W-1:0] root
);
	logic [SQ_REM_W-1:0] rem_s  [0:SQ_STAGES-1];
	logic [RAD_W-1:0]    root_s [0:SQ_STAGES-1];
	logic [SQ_W-1:0]     val_s  [0:SQ_STAGES-1];
	logic [SQ_REM_W-1:0] rem_n  [0:SQ_STAGES-1];
	logic [RAD_W-1:0]    root_n [0:SQ_STAGES-1];
	logic [SQ_W-1:0]     val_n  [0:SQ_STAGES-1];

	always_comb begin
		logic [SQ_REM_W-1:0] rem_i;
		logic [RAD_W-1:0]    root_i;
		logic [SQ_W-1:0]     val_i;
		logic [SQ_REM_W-1:0] cur;
		logic [SQ_REM_W-1:0] trial;
		for (int k = 0; k < SQ_STAGES; k++) begin
			if (k == 0) begin
				rem_i  = '0;
				root_i = '0;
				val_i  = value;
			end else begin
				rem_i  = rem_s[k-1];
				root_i = root_s[k-1];
				val_i  = val_s[k-1];
			end
			cur   = {rem_i[SQ_REM_W-3:0], val_i[SQ_W-1 -: 2]};
			trial = {1'b0, root_i, 2'b01};
			if (cur >= trial) begin
				rem_n[k]  = cur - trial;
				root_n[k] = {root_i[RAD_W-2:0], 1'b1};
			end else begin
				rem_n[k]  = cur;
				root_n[k] = {root_i[RAD_W-2:0], 1'b0};
			end
			val_n[k] = {val_i[SQ_W-3:0], 2'b00};
		end
	end

	always_ff @(posedge clk) begin
		if (ce) begin
			for (int k = 0; k < SQ_STAGES; k++) begin
				rem_s[k]  <= rem_n[k];
				root_s[k] <= root_n[k];
				val_s[k]  <= val_n[k];
			end
		end
	end

	assign root = root_s[SQ_STAGES-1];
endmodule

@@ rtl/cbc_div.sv @@
// Pipelined rounded division round(num / d), one quotient bit per stage.
// Depends on cbc_pkg.
module cbc_div
	import cbc_pkg::*;
(
	input  logic               clk,
	input  logic               ce,
	input  logic [SQ_W-1:0]    num,
	input  logic [RAD_W-1:0]   d,
	output logic [DIV_D_W-1:0] quot
);
	logic [DIV_D_W-1:0] rem_s [0:DIV_STAGES-1];
	logic [DIV_D_W-1:0] q_s   [0:DIV_STAGES-1];
	logic [DIV_D_W-1:0] lo_s  [0:DIV_STAGES-1];
	logic [DIV_D_W-1:0] den_s [0:DIV_STAGES-1];
	logic [DIV_D_W-1:0] rem_n [0:DIV_STAGES-1];
	logic [DIV_D_W-1:0] q_n   [0:DIV_STAGES-1];
	logic [DIV_D_W-1:0] lo_n  [0:DIV_STAGES-1];
	logic [DIV_D_W-1:0] den_n [0:DIV_STAGES-1];

	always_comb begin
		logic [DIV_N_W-1:0] dividend;
		logic [DIV_D_W-1:0] rem_i;
		logic [DIV_D_W-1:0] q_i;
		logic [DIV_D_W-1:0] lo_i;
		logic [DIV_D_W-1:0] den_i;
		logic [DIV_D_W:0]   cur;
		dividend = {num, 1'b0} + {{(DIV_N_W-RAD_W){1'b0}}, d};
		for (int k = 0; k < DIV_STAGES; k++) begin
			if (k == 0) begin
				rem_i = {1'b0, dividend[DIV_N_W-1:DIV_D_W]};
				q_i   = '0;
				lo_i  = dividend[DIV_D_W-1:0];
				den_i = {d, 1'b0};
			end else begin
				rem_i = rem_s[k-1];
				q_i   = q_s[k-1];
				lo_i  = lo_s[k-1];
				den_i = den_s[k-1];
			end
			cur = {rem_i, lo_i[DIV_D_W-1]};
			if (cur >= {1'b0, den_i}) begin
				rem_n[k] = DIV_D_W'(cur - {1'b0, den_i});
				q_n[k]   = {q_i[DIV_D_W-2:0], 1'b1};
			end else begin
				rem_n[k] = cur[DIV_D_W-1:0];
				q_n[k]   = {q_i[DIV_D_W-2:0], 1'b0};
			end
			lo_n[k]  = {lo_i[DIV_D_W-2:0], 1'b0};
			den_n[k] = den_i;
		end
	end

	always_ff @(posedge clk) begin
		if (ce) begin
			for (int k = 0; k < DIV_STAGES; k++) begin
				rem_s[k] <= rem_n[k];
				q_s[k]   <= q_n[k];
				lo_s[k]  <= lo_n[k];
				den_s[k] <= den_n[k];
			end
		end
	end

	assign quot = q_s[DIV_STAGES-1];
endmodule
